/* hdl/lcgr_pkg.sv */
package lcgr_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned DRAW_W = 15;
	localparam int unsigned DRAW_SHIFT = 16;
	localparam int unsigned STEP_CNT_W = $clog2(DRAW_W);

	localparam logic [DATA_W-1:0] LCG_MULT = 32'd1103515245;
	localparam logic [DATA_W-1:0] LCG_INC = 32'd12345;
	localparam logic [DATA_W-1:0] LCG_SEED_RST = 32'd1;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	typedef enum logic [1:0] {
		KIND_DRAW = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_RESEED = 2'd2
	} kind_t;

	// One classified job. For a reseed, data holds the seed; otherwise it holds
	// the lower bound, and span holds the unsigned width of the range.
	typedef struct packed {
		kind_t kind;
		logic [DATA_W-1:0] data;
		logic [DATA_W-1:0] span;
	} job_t;

endpackage

/* hdl/lcgr_in_if.sv */
interface lcgr_in_if
	import lcgr_pkg::*;
();
	logic valid;
	logic ready;
	logic mode;
	logic [DATA_W-1:0] seed_value;
	logic signed [DATA_W-1:0] low_bound;
	logic signed [DATA_W-1:0] high_bound;

	modport source (output valid, output mode, output seed_value, output low_bound,
		output high_bound, input ready);
	modport sink (input valid, input mode, input seed_value, input low_bound,
		input high_bound, output ready);
endinterface

/* hdl/lcgr_out_if.sv */
interface lcgr_out_if
	import lcgr_pkg::*;
();
	logic valid;
	logic ready;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

/* hdl/lcg_random_in_range.sv */
// Sequencing: a reseed or an empty-range transaction goes straight to the result
// register; a draw first passes a multiply, 15 remainder steps and a final add.
// The back end holds one job at a time, using the bit-serial remainder unit for
// draws; it takes the next job only after the previous result has been accepted.
// Reset: arst_n clears the job queue and the sequencer and sets the generator
// state to 1; no transaction is in flight after reset.
module lcg_random_in_range
	import lcgr_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	lcgr_in_if.sink req,
	lcgr_out_if.source rsp
);

	// The front end classifies each incoming transaction as a reseed, an empty
	// range or a real draw, and computes the unsigned span of the range.
	// Classified jobs wait in a short queue so that new requests are taken
	// while the back end is still busy with a remainder or holding a result.
	logic push;
	job_t push_job;
	logic queue_full;
	logic queue_empty;
	logic pop;
	job_t head_job;

	lcgr_front u_front (
		.req(req),
		.queue_full(queue_full),
		.push(push),
		.job(push_job)
	);

	lcgr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.head_job(head_job),
		.full(queue_full),
		.empty(queue_empty)
	);

	// The back end owns the generator state. It handles jobs strictly in
	// order, so the state advances exactly as the sequence of draws demands.
	// A draw advances the state with one multiply, extracts 15 bits, reduces
	// them by the span one bit per cycle, then adds the lower bound.
	lcgr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.queue_empty(queue_empty),
		.head_job(head_job),
		.pop(pop),
		.rsp(rsp)
	);

endmodule

/* hdl/lcgr_front.sv */
module lcgr_front
	import lcgr_pkg::*;
(
	lcgr_in_if.sink req,
	input logic queue_full,
	output logic push,
	output job_t job
);

	logic range_empty;

	assign range_empty = (req.high_bound <= req.low_bound);

	assign req.ready = !queue_full;
	assign push = req.valid && !queue_full;

	always_comb begin
		job.span = $unsigned(req.high_bound) - $unsigned(req.low_bound);
		if (req.mode) begin
			job.kind = KIND_RESEED;
			job.data = req.seed_value;
		end else if (range_empty) begin
			job.kind = KIND_EMPTY;
			job.data = $unsigned(req.low_bound);
		end else begin
			job.kind = KIND_DRAW;
			job.data = $unsigned(req.low_bound);
		end
	end

endmodule

/* hdl/lcgr_queue.sv */
module lcgr_queue
	import lcgr_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input job_t push_job,
	input logic pop,
	output job_t head_job,
	output logic full,
	output logic empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/lcgr_back.sv */
module lcgr_back
	import lcgr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic queue_empty,
	input job_t head_job,
	output logic pop,
	lcgr_out_if.source rsp
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL = 5'b00010,
		ST_DIV = 5'b00100,
		ST_ADD = 5'b01000,
		ST_OUT = 5'b10000
	} state_t;

	state_t state_q;
	logic [DATA_W-1:0] gen_state_q;
	logic [DATA_W-1:0] low_q;
	logic [DATA_W-1:0] span_q;
	logic [DRAW_W-1:0] draw_q;
	logic [DRAW_W-1:0] rem_q;
	logic [STEP_CNT_W-1:0] step_q;
	logic [DATA_W-1:0] value_q;

	logic [DATA_W-1:0] next_gen;
	logic [DRAW_W:0] trial;
	logic trial_fits;
	logic [DRAW_W-1:0] rem_next;

	assign next_gen = gen_state_q * LCG_MULT + LCG_INC;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	assign trial = {rem_q, draw_q[DRAW_W-1]};
	assign trial_fits = ({{(DATA_W-DRAW_W-1){1'b0}}, trial} >= span_q);
	assign rem_next = trial_fits ? DRAW_W'(trial - span_q[DRAW_W:0]) : trial[DRAW_W-1:0];

	assign pop = (state_q == ST_IDLE) && !queue_empty;
	assign rsp.valid = (state_q == ST_OUT);
	assign rsp.value = value_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				low_q <= head_job.data;
				span_q <= head_job.span;
				case (head_job.kind)
					KIND_RESEED: value_q <= '0;
					default: value_q <= head_job.data;
				endcase
			end
			ST_MUL: begin
				draw_q <= next_gen[DRAW_SHIFT +: DRAW_W];
				rem_q <= '0;
			end
			ST_DIV: begin
				draw_q <= {draw_q[DRAW_W-2:0], 1'b0};
				rem_q <= rem_next;
			end
			ST_ADD: begin
				value_q <= low_q + {{(DATA_W-DRAW_W){1'b0}}, rem_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gen_state_q <= LCG_SEED_RST;
			step_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!queue_empty) begin
						case (head_job.kind)
							KIND_RESEED: begin
								gen_state_q <= head_job.data;
								state_q <= ST_OUT;
							end
							KIND_DRAW: state_q <= ST_MUL;
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_MUL: begin
					gen_state_q <= next_gen;
					step_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_CNT_W'(DRAW_W - 1)) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: state_q <= ST_OUT;
				ST_OUT: begin
					if (rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
